/* design/lphm_pkg.sv */
// Package for the linear-probing hash map: slot word layout, FSM states,
// controller/datapath command and status structs, key mixing function.
// No dependencies.
`default_nettype none

package lphm_pkg;

  // Default log2 of the slot count.
  localparam int unsigned ADDR_BITS_DEF = 10;

  localparam int unsigned KEY_W = 63;
  localparam int unsigned VAL_W = 64;

  // FNV-64 prime = 2^40 + 435.
  localparam int unsigned PRIME_HI_SHIFT = 40;
  localparam logic [63:0] PRIME_LO       = 64'd435;

  localparam int unsigned MIX_SHIFT_A = 29;
  localparam int unsigned MIX_SHIFT_B = 32;

  // One table slot as stored in the RAM.
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_SEED,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture a new request
    logic hash1;     // first multiply
    logic hash2;     // xor-shift and second multiply
    logic seed;      // fold hash into start slot
    logic advance;   // step slot pointer and probe count
    logic record;    // latch the result and update the slot
    logic clear_wr;  // write an empty slot during the clearing sweep
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic resolved;   // probe ended: empty slot, key match or sweep done
    logic slot_last;  // slot pointer at the last slot
  } status_t;

  // Multiply by the prime modulo 2^64, as a shift plus a narrow product.
  function automatic logic [63:0] mul_prime(input logic [63:0] x);
    logic [63:0] lo;
    lo = x * PRIME_LO;
    return (x << PRIME_HI_SHIFT) + lo;
  endfunction

endpackage

`default_nettype wire

/* design/linear_probe_hash_map_core.sv */
// Top level of the linear-probing hash map core: controller plus datapath.
// Depends on lphm_pkg, lphm_ctrl, lphm_dp (and lphm_ram through lphm_dp).
//
//   Channel   Handshake         Payload
//   request   start / busy      op, key, put_value, default_value
//   result    done (strobe)     read_value, hit, table_full
//
// After accept an item is hashed (HASH1, HASH2, SEED) and then probes P slots
// (1 to 2^ADDR_BITS) with busy high; each probe is one registered
// RAM read plus a compare. The result is shown for one cycle with done, and a
// new item may be accepted in that same cycle.
// After reset the core sweeps all 2^ADDR_BITS slots to empty, one per cycle,
// with busy high. Results cannot be stalled.
`default_nettype none

module linear_probe_hash_map_core #(
  parameter int unsigned ADDR_BITS = lphm_pkg::ADDR_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              op,
  input  wire logic        [lphm_pkg::KEY_W-1:0] key,
  input  wire logic signed [lphm_pkg::VAL_W-1:0] put_value,
  input  wire logic signed [lphm_pkg::VAL_W-1:0] default_value,
  output logic                                   done,
  output logic signed      [lphm_pkg::VAL_W-1:0] read_value,
  output logic                                   hit,
  output logic                                   table_full
);

  lphm_pkg::cmd_t    cmd;
  lphm_pkg::status_t status;

  lphm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lphm_dp #(
    .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .op           (op),
    .key          (key),
    .put_value    (put_value),
    .default_value(default_value),
    .status       (status),
    .read_value   (read_value),
    .hit          (hit),
    .table_full   (table_full)
  );

  // Clearing sweep holds the core busy right after reset
  a_clear_busy: assert property (@(posedge clk) $past(rst) && !rst |-> busy)
    else $error("core not busy during clearing sweep");

  // An accepted transfer keeps the core busy through hashing
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##1 busy)
    else $error("core idle right after accepting a transfer");

  // A result is never both a hit and a full-table miss
  a_hit_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && table_full))
    else $error("result flags hit and table_full together");

  // A result strobe lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

/* design/lphm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lphm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/lphm_ctrl.sv */
// Controller FSM of the hash map: clearing sweep, hash sequencing, probe loop.
// Depends on lphm_pkg.
`default_nettype none

module lphm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire lphm_pkg::status_t status,
  output lphm_pkg::cmd_t         cmd,
  output logic                   busy,
  output logic                   done
);

  lphm_pkg::state_t state;
  lphm_pkg::state_t state_next;

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lphm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lphm_pkg::ST_CLEAR: begin
        if (status.slot_last) state_next = lphm_pkg::ST_IDLE;
      end
      lphm_pkg::ST_IDLE,
      lphm_pkg::ST_RESP: begin
        state_next = start ? lphm_pkg::ST_HASH1 : lphm_pkg::ST_IDLE;
      end
      lphm_pkg::ST_HASH1: state_next = lphm_pkg::ST_HASH2;
      lphm_pkg::ST_HASH2: state_next = lphm_pkg::ST_SEED;
      lphm_pkg::ST_SEED:  state_next = lphm_pkg::ST_READ;
      lphm_pkg::ST_READ:  state_next = lphm_pkg::ST_CHECK;
      lphm_pkg::ST_CHECK: begin
        state_next = status.resolved ? lphm_pkg::ST_RESP : lphm_pkg::ST_READ;
      end
      default: state_next = lphm_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      lphm_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.advance  = 1'b1;
      end
      lphm_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      lphm_pkg::ST_RESP: begin
        busy     = 1'b0;
        done     = 1'b1;
        cmd.load = start;
      end
      lphm_pkg::ST_HASH1: cmd.hash1 = 1'b1;
      lphm_pkg::ST_HASH2: cmd.hash2 = 1'b1;
      lphm_pkg::ST_SEED:  cmd.seed  = 1'b1;
      lphm_pkg::ST_READ:  cmd = '0;
      lphm_pkg::ST_CHECK: begin
        cmd.record  = status.resolved;
        cmd.advance = !status.resolved;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/lphm_dp.sv */
// Datapath of the hash map: request registers, key mixing, slot pointer,
// probe counter, slot RAM and result registers.
// Depends on lphm_pkg and lphm_ram.
`default_nettype none

module lphm_dp #(
  parameter int unsigned ADDR_BITS = lphm_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lphm_pkg::cmd_t                  cmd,
  input  wire logic                            op,
  input  wire logic        [lphm_pkg::KEY_W-1:0] key,
  input  wire logic signed [lphm_pkg::VAL_W-1:0] put_value,
  input  wire logic signed [lphm_pkg::VAL_W-1:0] default_value,
  output lphm_pkg::status_t                    status,
  output logic signed      [lphm_pkg::VAL_W-1:0] read_value,
  output logic                                 hit,
  output logic                                 table_full
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  // Request registers
  logic                       op_r;
  logic [lphm_pkg::KEY_W-1:0] key_r;
  logic [lphm_pkg::VAL_W-1:0] pval_r;
  logic [lphm_pkg::VAL_W-1:0] dval_r;

  // Hash pipeline registers and their xor-shifted values
  logic [63:0] h1;
  logic [63:0] h2;
  logic [63:0] h1_mixed;
  logic [63:0] h2_mixed;

  // Probe pointer and count
  logic [ADDR_BITS-1:0] slot;
  logic [ADDR_BITS-1:0] cnt;

  // RAM ports
  lphm_pkg::slot_t rd;
  lphm_pkg::slot_t wr;
  logic            we;

  logic slot_empty;
  logic key_match;
  logic cnt_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op;
      key_r  <= key;
      pval_r <= put_value;
      dval_r <= default_value;
    end
  end

  // Key mixing: multiply, xor-shift, multiply, xor-shift
  assign h1_mixed = h1 ^ (h1 >> lphm_pkg::MIX_SHIFT_A);
  assign h2_mixed = h2 ^ (h2 >> lphm_pkg::MIX_SHIFT_B);

  always_ff @(posedge clk) begin
    if (cmd.hash1) h1 <= lphm_pkg::mul_prime({1'b0, key_r});
    if (cmd.hash2) h2 <= lphm_pkg::mul_prime(h1_mixed);
  end

  // Slot pointer doubles as the clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      cnt  <= '0;
    end else if (cmd.seed) begin
      slot <= h2_mixed[ADDR_BITS-1:0];
      cnt  <= '0;
    end else if (cmd.advance) begin
      slot <= slot + 1'b1;
      cnt  <= cnt + 1'b1;
    end
  end

  // Probe status from the slot read
  assign slot_empty = !rd.used;
  assign key_match  = rd.used && (rd.key == key_r);
  assign cnt_last   = &cnt;

  assign status.resolved  = slot_empty || key_match || cnt_last;
  assign status.slot_last = &slot;

  // Slot write: clearing sweep, or a put that lands on an empty or matching slot
  assign we = cmd.clear_wr || (cmd.record && op_r && (slot_empty || key_match));

  always_comb begin
    if (cmd.clear_wr) begin
      wr = '0;
    end else begin
      wr.used  = 1'b1;
      wr.key   = key_r;
      wr.value = pval_r;
    end
  end

  lphm_ram #(
    .WIDTH(lphm_pkg::SLOT_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(slot),
    .wdata(wr),
    .raddr(slot),
    .rdata(rd)
  );

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.record) begin
      if (slot_empty) begin
        read_value <= op_r ? pval_r : dval_r;
        hit        <= 1'b0;
        table_full <= 1'b0;
      end else if (key_match) begin
        read_value <= op_r ? pval_r : rd.value;
        hit        <= 1'b1;
        table_full <= 1'b0;
      end else begin
        read_value <= op_r ? '0 : dval_r;
        hit        <= 1'b0;
        table_full <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for linear_probe_hash_map_core: puts and gets are predicted
// against a slot-accurate copy of the probe table, from empty through completely full.
// Depends on lphm_pkg and linear_probe_hash_map_core.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADDR_BITS = lphm_pkg::ADDR_BITS_DEF;
  localparam int unsigned KEY_W     = lphm_pkg::KEY_W;
  localparam int unsigned VAL_W     = lphm_pkg::VAL_W;
  localparam int unsigned SLOTS     = 1 << ADDR_BITS;
  localparam bit [63:0]   MIX_PRIME = 64'd1099511628211;
  localparam int unsigned FOLD_A    = 29;
  localparam int unsigned FOLD_B    = 32;
  localparam bit          OP_GET    = 1'b0;
  localparam bit          OP_PUT    = 1'b1;
  localparam bit [VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam bit [VAL_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    bit signed [VAL_W-1:0] read_value;
    bit                    hit;
    bit                    table_full;
  } outcome_t;

  // Shadow of the slot table plus the queue of outcomes still owed by the core.
  class slot_table_tracker;
    bit             used [SLOTS];
    bit [KEY_W-1:0] keys [SLOTS];
    bit [VAL_W-1:0] vals [SLOTS];
    int             occupied;
    int             errors;
    outcome_t       awaiting [$];

    // Start slot: multiply, fold, multiply, fold, keep the low bits.
    function bit [ADDR_BITS-1:0] home_slot(bit [KEY_W-1:0] k);
      bit [63:0] h;
      h = {1'b0, k} * MIX_PRIME;
      h = h ^ (h >> FOLD_A);
      h = h * MIX_PRIME;
      h = h ^ (h >> FOLD_B);
      return h[ADDR_BITS-1:0];
    endfunction

    // Walk the probe sequence for an accepted request and queue its outcome.
    function void record_request(bit is_put, bit [KEY_W-1:0] k, bit [VAL_W-1:0] pv,
                                 bit [VAL_W-1:0] dv);
      outcome_t            o;
      bit [ADDR_BITS-1:0]  s;
      bit                  resolved;
      o.read_value = is_put ? '0 : dv;
      o.hit        = 1'b0;
      o.table_full = 1'b1;
      s            = home_slot(k);
      resolved     = 1'b0;
      for (int n = 0; n < SLOTS && !resolved; n++) begin
        if (!used[s]) begin
          if (is_put) begin
            used[s] = 1'b1;
            keys[s] = k;
            vals[s] = pv;
            occupied++;
          end
          o.read_value = is_put ? pv : dv;
          o.table_full = 1'b0;
          resolved     = 1'b1;
        end else if (keys[s] == k) begin
          if (is_put) vals[s] = pv;
          o.read_value = is_put ? pv : vals[s];
          o.hit        = 1'b1;
          o.table_full = 1'b0;
          resolved     = 1'b1;
        end else begin
          s = s + 1'b1;
        end
      end
      awaiting.push_back(o);
    endfunction

    function void check_response(logic signed [VAL_W-1:0] rv, logic h, logic f);
      outcome_t o;
      if (awaiting.size() == 0) begin
        $error("result with no request outstanding: read_value %0d", rv);
        errors++;
        return;
      end
      o = awaiting.pop_front();
      if (rv !== o.read_value) begin
        $error("read_value: expected %0d, got %0d", o.read_value, rv);
        errors++;
      end
      if (h !== o.hit) begin
        $error("hit: expected %0b, got %0b", o.hit, h);
        errors++;
      end
      if (f !== o.table_full) begin
        $error("table_full: expected %0b, got %0b", o.table_full, f);
        errors++;
      end
    endfunction
  endclass

  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    start         = 1'b0;
  logic                    op            = 1'b0;
  logic [KEY_W-1:0]        key           = '0;
  logic signed [VAL_W-1:0] put_value     = '0;
  logic signed [VAL_W-1:0] default_value = '0;
  logic                    busy;
  logic                    done;
  logic signed [VAL_W-1:0] read_value;
  logic                    hit;
  logic                    table_full;

  slot_table_tracker tracker = new();
  bit [KEY_W-1:0]    stored_keys [$];
  bit                gaps_on;

  linear_probe_hash_map_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .key(key),
    .put_value(put_value),
    .default_value(default_value),
    .done(done),
    .read_value(read_value),
    .hit(hit),
    .table_full(table_full)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Results cannot be held off: check every strobe.
  always @(posedge clk) begin
    if (!rst && done) tracker.check_response(read_value, hit, table_full);
  end

  function automatic bit [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [KEY_W-1:0] fresh_key();
    bit [63:0] w;
    w = rand_word();
    return w[KEY_W-1:0];
  endfunction

  // Mostly random values, now and then an extreme.
  function automatic bit [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return rand_word();
    endcase
  endfunction

  function automatic bit [KEY_W-1:0] known_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // Present one request and hold it until the transfer; called at a rising edge.
  task automatic issue(bit is_put, bit [KEY_W-1:0] k, bit [VAL_W-1:0] pv,
                       bit [VAL_W-1:0] dv);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start         <= 1'b1;
    op            <= is_put;
    key           <= k;
    put_value     <= pv;
    default_value <= dv;
    do @(posedge clk); while (busy);
    if (is_put && tracker.occupied < SLOTS) stored_keys.push_back(k);
    tracker.record_request(is_put, k, pv, dv);
  endtask

  initial begin
    bit [KEY_W-1:0] chain [4];
    bit [KEY_W-1:0] k;
    bit [KEY_W-1:0] probe_key;
    int             found;
    int             count;
    int             waited;

    repeat (9) @(posedge clk);
    rst     <= 1'b0;
    gaps_on = 1'b0;

    // Four keys that all start at the last slot: collisions and wrap-around.
    found     = 0;
    probe_key = 63'h0123_4567_0000_0000;
    while (found < 4) begin
      if (tracker.home_slot(probe_key) == SLOTS - 1) begin
        chain[found] = probe_key;
        found++;
      end
      probe_key = probe_key + 1'b1;
    end

    // Directed: key and value extremes, overwrite, colliding chain, miss past a cluster.
    issue(OP_GET, '0, '0, VAL_MIN);
    issue(OP_PUT, '0, VAL_MAX, '0);
    issue(OP_GET, '0, '0, '0);
    issue(OP_PUT, '0, VAL_MIN, VAL_MAX);
    issue(OP_GET, '1, '1, VAL_MAX);
    issue(OP_PUT, '1, '1, '0);
    issue(OP_GET, '1, '0, '0);
    issue(OP_PUT, 63'h2AAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    issue(OP_GET, 63'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(OP_PUT, 63'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(OP_GET, 63'h5555_5555_5555_5555, '0, '0);
    for (int i = 0; i < 3; i++) issue(OP_PUT, chain[i], rand_word(), rand_word());
    for (int i = 2; i >= 0; i--) issue(OP_GET, chain[i], rand_word(), rand_word());
    issue(OP_PUT, chain[1], VAL_MIN, '0);
    issue(OP_GET, chain[1], '0, VAL_MAX);
    issue(OP_GET, chain[3], '0, 64'h0000_0000_0000_0001);
    issue(OP_PUT, chain[3], '0, '1);
    issue(OP_GET, chain[3], '1, '1);

    // Random mix over a modest working set, with and without sender gaps.
    for (int i = 0; i < 500; i++) begin
      gaps_on = ((i / 60) % 2 == 0);
      k = ($urandom_range(0, 9) < 3) ? fresh_key() : known_key();
      issue(1'($urandom_range(0, 1)), k, pick_value(), pick_value());
    end

    // Fill the table to the last slot, with lookups mixed in.
    count = 0;
    while (tracker.occupied < SLOTS) begin
      gaps_on = ((count / 80) % 2 == 0);
      case ($urandom_range(0, 19))
        0, 1, 2: issue(OP_GET, known_key(), pick_value(), pick_value());
        3:       issue(OP_GET, fresh_key(), pick_value(), pick_value());
        default: issue(OP_PUT, fresh_key(), pick_value(), pick_value());
      endcase
      count++;
    end

    // Full table: misses sweep every slot, present keys still resolve.
    gaps_on = 1'b0;
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0:       issue(OP_PUT, fresh_key(), pick_value(), pick_value());
        1:       issue(OP_GET, fresh_key(), pick_value(), pick_value());
        2:       issue(OP_PUT, known_key(), pick_value(), pick_value());
        default: issue(OP_GET, known_key(), pick_value(), pick_value());
      endcase
    end
    start <= 1'b0;

    // Drain: the longest item is a full sweep of every slot.
    waited = 0;
    while (tracker.awaiting.size() != 0 && waited < 4 * SLOTS + 64) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (tracker.awaiting.size() != 0) begin
      $error("%0d results never arrived", tracker.awaiting.size());
      tracker.errors += tracker.awaiting.size();
    end

    if (tracker.errors == 0) begin
      $display("linear_probe_hash_map_core verification clean");
    end else begin
      $display("linear_probe_hash_map_core verification failed");
    end
    $finish;
  end

  // Watchdog, well beyond every item taking a full sweep.
  initial begin
    #50_000_000;
    $display("linear_probe_hash_map_core verification failed");
    $finish;
  end

endmodule
